/* rtl/lha_pkg.sv */
// Package for the latency histogram accounting block: codes and types.
package lha_pkg;

    localparam int unsigned DATA_W = 64;

    typedef enum logic [2:0] {
        CMD_STAGE_START  = 3'd0,
        CMD_STAGE_END    = 3'd1,
        CMD_COUNT        = 3'd2,
        CMD_SHRINK_START = 3'd3,
        CMD_SHRINK_END   = 3'd4,
        CMD_PASS_END     = 3'd5,
        CMD_QUERY        = 3'd6,
        CMD_NONE         = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        QK_DELAY     = 3'd0,
        QK_COUNT     = 3'd1,
        QK_SCANNED   = 3'd2,
        QK_RECLAIMED = 3'd3,
        QK_SHRINK    = 3'd4
    } qkind_t;

    typedef enum logic [2:0] {
        REG_ENABLE = 3'd0,
        REG_THR0   = 3'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_LEVEL,
        ST_ACCUM,
        ST_QSUM,
        ST_OUT
    } state_t;

    localparam logic [DATA_W-1:0] THR_RESET [6] = '{
        64'd0, 64'd50000000, 64'd100000000, 64'd200000000,
        64'd500000000, 64'd1000000000
    };

endpackage

/* rtl/latency_histogram_accounting.sv */
// Latency histogram accounting block: per-pass stage timing and level totals.
// Commands: stage, count and shrinker commands finish at the accepting edge; a query
//   result is registered in the ST_OUT state, an all-levels sum in the last ST_QSUM step.
// Pass end: the fold, level search and accumulate states run in that order,
//   with in_ready low throughout.
// Throughput: one transaction at a time; a query result must be taken before the next.
// Reset: all counters and control clear, totals read as zero; thresholds take defaults.
module latency_histogram_accounting
    import lha_pkg::*;
#(
    parameter int unsigned STAGE_COUNT = 4,
    parameter int unsigned LEVEL_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [1:0]  stage,
    input  logic [63:0] timestamp,
    input  logic [63:0] reclaim_add,
    input  logic [63:0] scan_add,
    input  logic [63:0] shrinker_id,
    input  logic [2:0]  query_kind,
    input  logic [2:0]  level,
    input  logic        all_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] query_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned SW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam int unsigned LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int unsigned TN = STAGE_COUNT * LEVEL_COUNT;
    localparam int unsigned TW = $clog2(TN);

    // Configuration
    logic        enable_reg;
    logic [63:0] thr_reg [LEVEL_COUNT];

    // Per-pass state
    logic [63:0] st_start_reg [STAGE_COUNT];
    logic [63:0] st_delay_reg [STAGE_COUNT];
    logic [63:0] st_scan_reg  [STAGE_COUNT];
    logic [63:0] st_recl_reg  [STAGE_COUNT];
    logic [63:0] sh_start_reg, sh_max_reg, sh_id_reg;
    logic [63:0] tot_sh_id_reg, tot_sh_max_reg;

    // Totals memories, one write port each, registered read
    logic [63:0] mem_delay [TN];
    logic [63:0] mem_count [TN];
    logic [63:0] mem_scan  [TN];
    logic [63:0] mem_recl  [TN];
    // Entries are valid once written; a clear entry reads as zero
    logic [TN-1:0] tvalid_reg;

    state_t      state_reg, state_next;
    logic [SW-1:0] sidx_reg;   // stage walker
    logic [LW-1:0] lidx_reg;   // level walker
    logic [LW-1:0] lvl_reg;    // chosen level
    logic [63:0] acc_reg;
    logic [63:0] out_reg;
    logic        out_valid_reg;
    logic [2:0]  qk_reg;
    logic        rd_pend_reg;   // query is in range and reads the totals
    logic [63:0] rd_d, rd_c, rd_s, rd_r;
    logic        rd_v_reg;

    logic        in_acc, busy;
    logic [SW-1:0] st_i;
    logic        stage_ok;
    logic [TW-1:0] rd_addr;

    assign stage_ok = (4'(stage) < 4'(STAGE_COUNT));
    assign st_i     = SW'(stage);
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign query_value = out_reg;
    assign busy = (state_reg != ST_IDLE);

    // Shared adder and comparator
    logic [63:0] add_a, add_b, add_y;
    logic [63:0] cmp_a, cmp_b;
    logic        cmp_ge;
    assign add_y  = add_a + add_b;
    assign cmp_ge = (cmp_a >= cmp_b);

    // Read address mux
    always_comb
    begin
        if (state_reg == ST_QSUM)
        begin
            rd_addr = TW'(lidx_reg * STAGE_COUNT + sidx_reg);
        end
        else if (state_reg == ST_ACCUM || state_reg == ST_LEVEL)
        begin
            rd_addr = TW'(lvl_reg * STAGE_COUNT + sidx_reg);
        end
        else
        begin
            rd_addr = TW'(level * STAGE_COUNT + st_i);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_d <= mem_delay[rd_addr];
        rd_c <= mem_count[rd_addr];
        rd_s <= mem_scan[rd_addr];
        rd_r <= mem_recl[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= tvalid_reg[rd_addr];
        end
    end

    // Qualified read data
    logic [63:0] q_d, q_c, q_s, q_r;
    assign q_d = rd_v_reg ? rd_d : '0;
    assign q_c = rd_v_reg ? rd_c : '0;
    assign q_s = rd_v_reg ? rd_s : '0;
    assign q_r = rd_v_reg ? rd_r : '0;

    // Pass end, accumulate step: four adds per stage, split over a read phase and a write phase
    // sub-phase: 0 = issue read, 1 = write delay/count/scan/recl
    logic phase_reg;
    logic last_s, last_l;
    assign last_s = (sidx_reg == SW'(STAGE_COUNT - 1));
    assign last_l = (lidx_reg == LW'(LEVEL_COUNT - 1));

    // Adder operand select
    always_comb
    begin
        add_a = acc_reg;
        add_b = '0;
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            ST_FOLD:
            begin
                add_a = st_scan_reg[0];
                add_b = st_scan_reg[sidx_reg];
            end
            ST_LEVEL:
            begin
                cmp_a = st_delay_reg[0];
                cmp_b = thr_reg[lidx_reg];
            end
            ST_ACCUM:
            begin
                add_a = q_d;
                add_b = st_delay_reg[sidx_reg];
            end
            ST_QSUM:
            begin
                add_a = acc_reg;
                add_b = (qk_reg == QK_SCANNED) ? q_s : q_r;
            end
            default:
            begin
                if (cmd == CMD_STAGE_END)
                begin
                    add_a = st_delay_reg[st_i];
                    add_b = timestamp - st_start_reg[st_i];
                end
                else if (cmd == CMD_PASS_END)
                begin
                    add_a = st_delay_reg[0];
                    add_b = timestamp - st_start_reg[0];
                end
                else
                begin
                    add_a = st_scan_reg[st_i];
                    add_b = scan_add;
                end
                cmp_a = timestamp - sh_start_reg;
                cmp_b = sh_max_reg;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == CMD_QUERY)
                    begin
                        if (query_kind == QK_SCANNED || query_kind == QK_RECLAIMED)
                        begin
                            state_next = all_levels ? ST_QSUM : ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    else if (cmd == CMD_PASS_END && enable_reg)
                    begin
                        state_next = ST_FOLD;
                    end
                end
            end
            ST_FOLD:  if (last_s) state_next = ST_LEVEL;
            ST_LEVEL: if (phase_reg) state_next = ST_ACCUM;
            ST_ACCUM: if (phase_reg && last_s) state_next = ST_IDLE;
            ST_QSUM:  if (phase_reg && last_l) state_next = ST_IDLE;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            for (int i = 0; i < LEVEL_COUNT; i++)
            begin
                thr_reg[i] <= THR_RESET[i];
            end
            for (int i = 0; i < STAGE_COUNT; i++)
            begin
                st_start_reg[i] <= '0;
                st_delay_reg[i] <= '0;
                st_scan_reg[i]  <= '0;
                st_recl_reg[i]  <= '0;
            end
            sh_start_reg   <= '0;
            sh_max_reg     <= '0;
            sh_id_reg      <= '0;
            tot_sh_id_reg  <= '0;
            tot_sh_max_reg <= '0;
            tvalid_reg     <= '0;
            sidx_reg       <= '0;
            lidx_reg       <= '0;
            lvl_reg        <= '0;
            acc_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            qk_reg         <= '0;
            rd_pend_reg    <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ENABLE)
                begin
                    enable_reg <= cfg_data[0];
                end
                for (int i = 0; i < LEVEL_COUNT; i++)
                begin
                    if (cfg_index == 3'(int'(REG_THR0) + i))
                    begin
                        thr_reg[i] <= cfg_data;
                    end
                end
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    lidx_reg  <= '0;
                    phase_reg <= 1'b0;
                    qk_reg    <= query_kind;
                    if (in_acc && cmd == CMD_QUERY)
                    begin
                        // query setup: range checks and the stage column
                        sidx_reg <= st_i;
                        if (query_kind == QK_SHRINK)
                        begin
                            rd_pend_reg <= 1'b0;
                            acc_reg     <= {63'd0, (stage == 2'd0)};
                        end
                        else if ((query_kind == QK_SCANNED || query_kind == QK_RECLAIMED)
                                 && all_levels)
                        begin
                            // level ignored; no column gives a zero result
                            rd_pend_reg <= stage_ok;
                            acc_reg     <= '0;
                        end
                        else
                        begin
                            rd_pend_reg <= stage_ok && ({1'b0, level} < 4'(LEVEL_COUNT));
                            acc_reg     <= '0;
                        end
                    end
                    else
                    begin
                        sidx_reg <= SW'(1 % STAGE_COUNT);
                        acc_reg  <= '0;
                        if (in_acc && enable_reg)
                        begin
                            unique case (cmd)
                                CMD_STAGE_START:
                                    if (stage_ok) st_start_reg[st_i] <= timestamp;
                                CMD_STAGE_END:
                                    if (stage_ok) st_delay_reg[st_i] <= add_y;
                                CMD_COUNT:
                                    if (stage_ok)
                                    begin
                                        st_scan_reg[st_i] <= add_y;
                                        st_recl_reg[st_i] <= st_recl_reg[st_i] + reclaim_add;
                                    end
                                CMD_SHRINK_START:
                                    sh_start_reg <= timestamp;
                                CMD_SHRINK_END:
                                    if (cmp_ge && (cmp_a != cmp_b))
                                    begin
                                        sh_max_reg <= cmp_a;
                                        sh_id_reg  <= shrinker_id;
                                    end
                                CMD_PASS_END:
                                begin
                                    st_delay_reg[0] <= add_y;
                                    tot_sh_id_reg   <= sh_id_reg;
                                    tot_sh_max_reg  <= sh_max_reg;
                                    sh_id_reg       <= '0;
                                    sh_max_reg      <= '0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_FOLD:
                begin
                    // scanned uses shared adder, reclaimed its own adder
                    st_scan_reg[0] <= add_y;
                    st_recl_reg[0] <= st_recl_reg[0] + st_recl_reg[sidx_reg];
                    if (last_s)
                    begin
                        sidx_reg <= '0;
                        lidx_reg <= LW'(LEVEL_COUNT - 1);
                        lvl_reg  <= '0;
                    end
                    else
                    begin
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                end
                ST_LEVEL:
                begin
                    // search from top level down; phase set on first hit or at 0
                    if (!phase_reg)
                    begin
                        if (cmp_ge || lidx_reg == '0)
                        begin
                            lvl_reg   <= cmp_ge ? lidx_reg : '0;
                            phase_reg <= 1'b1;
                        end
                        else
                        begin
                            lidx_reg <= lidx_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                    end
                end
                ST_ACCUM:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        tvalid_reg[rd_addr] <= 1'b1;
                        st_delay_reg[sidx_reg] <= '0;
                        st_scan_reg[sidx_reg]  <= '0;
                        st_recl_reg[sidx_reg]  <= '0;
                        sidx_reg <= sidx_reg + 1'b1;
                    end
                end
                ST_QSUM:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        acc_reg   <= add_y;
                        lidx_reg  <= lidx_reg + 1'b1;
                        if (last_l)
                        begin
                            out_reg       <= rd_pend_reg ? add_y : '0;
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (qk_reg == QK_SHRINK)
                    begin
                        out_reg <= (sidx_reg == '0 && acc_reg[0]) ? tot_sh_id_reg
                                                                  : tot_sh_max_reg;
                    end
                    else if (rd_pend_reg)
                    begin
                        unique case (qk_reg)
                            QK_DELAY:     out_reg <= q_d;
                            QK_COUNT:     out_reg <= q_c;
                            QK_SCANNED:   out_reg <= q_s;
                            QK_RECLAIMED: out_reg <= q_r;
                            default:      out_reg <= '0;
                        endcase
                    end
                    else
                    begin
                        out_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Totals memory writes in the write phase (phase_reg high) of each accumulate step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACCUM && phase_reg)
        begin
            mem_delay[rd_addr] <= add_y;
            mem_count[rd_addr] <= q_c + 64'd1;
            mem_scan[rd_addr]  <= q_s + st_scan_reg[sidx_reg];
            mem_recl[rd_addr]  <= q_r + st_recl_reg[sidx_reg];
        end
    end

    // Assertions
    a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("input ready while busy");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(query_value))
        else $error("result dropped");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> state_reg == ST_IDLE) else $error("config while busy");

endmodule
